[sv/rbf_pkg.sv]
// Shared types, constants and helpers for the RBF interpolant evaluator.
package rbf_pkg;

  // defaults handed to the top level parameters
  localparam int MAX_CENTERS_DEF   = 256;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int CoordW   = 24;
  localparam int WeightW  = 32;
  localparam int IndexW   = 8;
  localparam int ValueW   = 64;
  localparam int KindW    = 2;
  localparam int CountW   = 9;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  // squared distance of two Q8.16 points stays below 2^50
  localparam int R2W = 50;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegKernelKind  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCenterCount = 2'd1;

  // ln(2) in Q0.32 and the two clip limits
  localparam logic [63:0] Ln2Q32 = 64'h0000_0000_B172_17F8;
  localparam logic [63:0] PosCap = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegCap = 64'h8000_0000_0000_0000;

  typedef enum logic [KindW-1:0] {
    KIND_TPS  = 2'd0,
    KIND_BIH  = 2'd1,
    KIND_TRI  = 2'd2,
    KIND_NONE = 2'd3
  } kernel_kind_e;

  // one classified word from front to back
  typedef struct packed {
    logic                      is_query;
    logic [IndexW-1:0]         center_index;
    logic signed [CoordW-1:0]  point_x;
    logic signed [CoordW-1:0]  point_y;
    logic signed [CoordW-1:0]  point_z;
    logic signed [WeightW-1:0] weight;
  } rbf_item_t;

  // shared multiplier request and response
  typedef struct packed {
    logic        go;
    logic [63:0] a;
    logic [63:0] b;
  } rbf_mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } rbf_mul_rsp_t;

endpackage

[sv/rbf_ifs.sv]
// Handshake interfaces for the input and result channels.
interface rbf_in_if import rbf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [IndexW-1:0]         center_index;
  logic signed [CoordW-1:0]  point_x;
  logic signed [CoordW-1:0]  point_y;
  logic signed [CoordW-1:0]  point_z;
  logic signed [WeightW-1:0] weight;

  modport source (output valid, opcode, center_index, point_x, point_y, point_z, weight,
                  input ready);
  modport sink (input valid, opcode, center_index, point_x, point_y, point_z, weight,
                output ready);
endinterface

interface rbf_out_if import rbf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] interpolated_value;
  logic                     saturated;

  modport source (output valid, interpolated_value, saturated, input ready);
  modport sink (input valid, interpolated_value, saturated, output ready);
endinterface

[sv/rbf_front.sv]
// Front end: accepts words, drops out-of-range loads, two-entry queue to the back end.
module rbf_front import rbf_pkg::*; #(
  parameter int MAX_CENTERS = MAX_CENTERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbf_in_if.sink    in_i,
  output rbf_item_t item_o,
  output logic      item_valid_o,
  input  logic      item_ready_i
);

  rbf_item_t  fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       keep, push, pop;

  // loads to slots beyond the table are dropped here
  assign keep = in_i.opcode | (int'(in_i.center_index) < MAX_CENTERS);
  assign in_i.ready = (cnt_q != 2'd2);
  assign push = in_i.valid & in_i.ready & keep;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop = item_valid_o & item_ready_i;
  assign item_o = fifo_q[rd_q];

  // queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{is_query: in_i.opcode, center_index: in_i.center_index,
                        point_x: in_i.point_x, point_y: in_i.point_y,
                        point_z: in_i.point_z, weight: in_i.weight};
    end
  end

endmodule

[sv/rbf_mul.sv]
// Shared 64x64 multiplier, one 64x16 partial product a cycle.
module rbf_mul import rbf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rbf_mul_req_t req_i,
  output rbf_mul_rsp_t rsp_o
);

  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [1:0]   k_q;
  logic         busy_q, done_q;
  logic [15:0]  slice;
  logic [79:0]  pp;

  assign slice = b_q[{k_q, 4'b0000} +: 16];
  assign pp    = {16'b0, a_q} * {64'b0, slice};

  // partial product accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      k_q    <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        acc_q  <= '0;
        k_q    <= 2'd0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_q + ({48'b0, pp} << {k_q, 4'b0000});
        k_q   <= k_q + 2'd1;
        if (k_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o = '{done: done_q, prod: acc_q};

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && $past(k_q) == 2'd3)
    else $error("multiplier done without a finished pass");

endmodule

[sv/rbf_back.sv]
// Back end: centre table, per-centre kernel sequencer and saturating accumulator.
module rbf_back import rbf_pkg::*; #(
  parameter int MAX_CENTERS   = MAX_CENTERS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  rbf_item_t           item_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  output rbf_mul_req_t        mul_req_o,
  input  rbf_mul_rsp_t        mul_rsp_i,
  rbf_out_if.source           out_o
);

  localparam int IW   = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int CW   = $clog2(MAX_CENTERS + 1);
  localparam int EntW = 3 * CoordW + WeightW;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DIFF, S_MUL, S_SQRT, S_NORM, S_LOG, S_LN, S_TERM, S_ACC, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_SQX, OP_SQY, OP_SQZ, OP_TRI, OP_LN, OP_TPS, OP_TERM
  } op_e;

  // floor(p / 2^sh) clipped to the cap; top bit flags clipping
  function automatic logic [64:0] shr_cap(input logic [127:0] p, input int unsigned sh,
                                          input logic neg);
    logic [127:0] s;
    logic [63:0]  cap;
    s   = p >> sh;
    cap = neg ? NegCap : PosCap;
    if ((|s[127:64]) || (s[63:0] > cap)) return {1'b1, cap};
    return {1'b0, s[63:0]};
  endfunction

  function automatic logic [CoordW:0] abs_diff(input logic [CoordW-1:0] a,
                                               input logic [CoordW-1:0] b);
    logic [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    return d[CoordW] ? (~d + 1'b1) : d;
  endfunction

  // configuration
  kernel_kind_e      kind_q;
  logic [CountW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_TPS;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKernelKind:  kind_q  <= kernel_kind_e'(cfg_data_i[KindW-1:0]);
        RegCenterCount: count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  state_e                state_q;
  op_e                   op_q;
  logic [CW-1:0]         idx_q, n_q;
  logic [CoordW-1:0]     qx_q, qy_q, qz_q;
  logic [EntW-1:0]       mem_q [MAX_CENTERS];
  logic [EntW-1:0]       ent_q;
  logic [CoordW:0]       ay_q, az_q;
  logic [R2W-1:0]        r2_q, nrm_q;
  logic [WeightW:0]      wmag_q;
  logic                  wneg_q, kneg_q, tneg_q;
  logic [63:0]           kmag_q, v_q, res_q, sbit_q, term_q, acc_q;
  logic [5:0]            e_q;
  logic [31:0]           m_q;
  logic [29:0]           frac_q;
  logic [4:0]            stp_q;
  logic                  sat_q;
  rbf_mul_req_t          mreq_q;
  logic                  out_valid_q, out_sat_q;
  logic [ValueW-1:0]     out_val_q;

  logic                  pop, mem_we;
  logic [IW-1:0]         waddr, raddr;
  logic [CW-1:0]         n_c;
  logic [CoordW:0]       ax_c, ay_c, az_c;
  logic [WeightW-1:0]    w_c;
  logic [WeightW:0]      wmag_c;
  logic [R2W-1:0]        r2_sum;
  logic [63:0]           rb, v_n, res_n;
  logic                  ge;
  logic [63:0]           sq;
  logic [32:0]           sq31;
  logic signed [7:0]     ex;
  logic signed [37:0]    lg;
  logic [37:0]           lgmag;
  logic [64:0]           cap_tri, cap_ln, cap_tps, cap_term;
  logic [63:0]           sum;
  logic                  ovf;

  assign item_ready_o = (state_q == S_IDLE);
  assign pop    = item_valid_i & item_ready_o;
  assign mem_we = pop & ~item_i.is_query;
  assign waddr  = IW'(item_i.center_index);
  assign raddr  = idx_q[IW-1:0];
  assign n_c    = (int'(count_q) > MAX_CENTERS) ? CW'(MAX_CENTERS) : CW'(count_q);

  // centre table, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= {item_i.point_x, item_i.point_y, item_i.point_z, item_i.weight};
    ent_q <= mem_q[raddr];
  end

  // datapath helpers
  always_comb begin
    ax_c   = abs_diff(qx_q, ent_q[EntW-1 -: CoordW]);
    ay_c   = abs_diff(qy_q, ent_q[EntW-CoordW-1 -: CoordW]);
    az_c   = abs_diff(qz_q, ent_q[EntW-2*CoordW-1 -: CoordW]);
    w_c    = ent_q[WeightW-1:0];
    wmag_c = w_c[WeightW-1] ? ({1'b1, {WeightW{1'b0}}} - {1'b0, w_c}) : {1'b0, w_c};
    r2_sum = r2_q + mul_rsp_i.prod[R2W-1:0];
    // one digit of the square root
    rb     = res_q + sbit_q;
    ge     = (v_q >= rb);
    v_n    = ge ? (v_q - rb) : v_q;
    res_n  = ge ? ((res_q >> 1) + sbit_q) : (res_q >> 1);
    // one bit of the log2 fraction
    sq     = {32'b0, m_q} * {32'b0, m_q};
    sq31   = sq[63:31];
    ex     = $signed({2'b00, e_q}) - $signed(8'(2 * FRACTION_BITS));
    lg     = $signed({ex, 30'b0}) + $signed({8'b0, frac_q});
    lgmag  = lg[37] ? 38'(-lg) : 38'(lg);
    cap_tri  = shr_cap(mul_rsp_i.prod, 2 * FRACTION_BITS, 1'b0);
    cap_ln   = shr_cap(mul_rsp_i.prod, 32, 1'b0);
    cap_tps  = shr_cap(mul_rsp_i.prod, FRACTION_BITS + 31, 1'b0);
    cap_term = shr_cap(mul_rsp_i.prod, FRACTION_BITS, tneg_q);
    // saturating accumulate
    sum    = acc_q + term_q;
    ovf    = (acc_q[63] == term_q[63]) && (sum[63] != acc_q[63]);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_SQX;
      idx_q       <= '0;
      n_q         <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      qz_q        <= '0;
      ay_q        <= '0;
      az_q        <= '0;
      r2_q        <= '0;
      nrm_q       <= '0;
      wmag_q      <= '0;
      wneg_q      <= 1'b0;
      kneg_q      <= 1'b0;
      tneg_q      <= 1'b0;
      kmag_q      <= '0;
      v_q         <= '0;
      res_q       <= '0;
      sbit_q      <= '0;
      term_q      <= '0;
      acc_q       <= '0;
      e_q         <= '0;
      m_q         <= '0;
      frac_q      <= '0;
      stp_q       <= '0;
      sat_q       <= 1'b0;
      mreq_q      <= '0;
      out_valid_q <= 1'b0;
      out_sat_q   <= 1'b0;
      out_val_q   <= '0;
    end else begin
      mreq_q.go <= 1'b0;
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (pop && item_i.is_query) begin
            qx_q  <= item_i.point_x;
            qy_q  <= item_i.point_y;
            qz_q  <= item_i.point_z;
            n_q   <= n_c;
            idx_q <= '0;
            acc_q <= '0;
            sat_q <= 1'b0;
            state_q <= (n_c == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: state_q <= S_DIFF;
        S_DIFF: begin
          ay_q   <= ay_c;
          az_q   <= az_c;
          wneg_q <= w_c[WeightW-1];
          wmag_q <= wmag_c;
          r2_q   <= '0;
          mreq_q <= '{go: 1'b1, a: 64'(ax_c), b: 64'(ax_c)};
          op_q   <= OP_SQX;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (mul_rsp_i.done) begin
            unique case (op_q)
              OP_SQX: begin
                r2_q   <= mul_rsp_i.prod[R2W-1:0];
                mreq_q <= '{go: 1'b1, a: 64'(ay_q), b: 64'(ay_q)};
                op_q   <= OP_SQY;
              end
              OP_SQY: begin
                r2_q   <= r2_sum;
                mreq_q <= '{go: 1'b1, a: 64'(az_q), b: 64'(az_q)};
                op_q   <= OP_SQZ;
              end
              OP_SQZ: begin
                r2_q   <= r2_sum;
                kneg_q <= 1'b0;
                kmag_q <= '0;
                unique case (kind_q) inside
                  KIND_TPS: begin
                    if (r2_sum == '0) begin
                      state_q <= S_TERM;
                    end else begin
                      nrm_q   <= r2_sum;
                      e_q     <= 6'(R2W - 1);
                      state_q <= S_NORM;
                    end
                  end
                  KIND_BIH, KIND_TRI: begin
                    v_q     <= 64'(r2_sum);
                    res_q   <= '0;
                    sbit_q  <= 64'h4000_0000_0000_0000;
                    state_q <= S_SQRT;
                  end
                  default: state_q <= S_TERM;
                endcase
              end
              OP_TRI: begin
                kmag_q  <= cap_tri[63:0];
                sat_q   <= sat_q | cap_tri[64];
                state_q <= S_TERM;
              end
              OP_LN: begin
                sat_q  <= sat_q | cap_ln[64];
                mreq_q <= '{go: 1'b1, a: 64'(r2_q), b: cap_ln[63:0]};
                op_q   <= OP_TPS;
              end
              OP_TPS: begin
                kmag_q  <= cap_tps[63:0];
                sat_q   <= sat_q | cap_tps[64];
                state_q <= S_TERM;
              end
              OP_TERM: begin
                term_q  <= tneg_q ? (64'd0 - cap_term[63:0]) : cap_term[63:0];
                sat_q   <= sat_q | cap_term[64];
                state_q <= S_ACC;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SQRT: begin
          v_q    <= v_n;
          res_q  <= res_n;
          sbit_q <= sbit_q >> 2;
          if (sbit_q == 64'd1) begin
            if (kind_q == KIND_BIH) begin
              kmag_q  <= res_n;
              state_q <= S_TERM;
            end else begin
              mreq_q  <= '{go: 1'b1, a: 64'(r2_q), b: res_n};
              op_q    <= OP_TRI;
              state_q <= S_MUL;
            end
          end
        end
        S_NORM: begin
          // leading-one search, one place a cycle
          if (nrm_q[R2W-1]) begin
            m_q     <= nrm_q[R2W-1 -: 32];
            frac_q  <= '0;
            stp_q   <= '0;
            state_q <= S_LOG;
          end else begin
            nrm_q <= nrm_q << 1;
            e_q   <= e_q - 6'd1;
          end
        end
        S_LOG: begin
          m_q    <= sq31[32] ? sq31[32:1] : sq31[31:0];
          frac_q <= {frac_q[28:0], sq31[32]};
          stp_q  <= stp_q + 5'd1;
          if (stp_q == 5'd29) state_q <= S_LN;
        end
        S_LN: begin
          kneg_q  <= lg[37];
          mreq_q  <= '{go: 1'b1, a: 64'(lgmag), b: Ln2Q32};
          op_q    <= OP_LN;
          state_q <= S_MUL;
        end
        S_TERM: begin
          tneg_q  <= wneg_q ^ kneg_q;
          mreq_q  <= '{go: 1'b1, a: 64'(wmag_q), b: kmag_q};
          op_q    <= OP_TERM;
          state_q <= S_MUL;
        end
        S_ACC: begin
          acc_q <= ovf ? (acc_q[63] ? NegCap : PosCap) : sum;
          sat_q <= sat_q | ovf;
          idx_q <= idx_q + 1'b1;
          state_q <= (idx_q + 1'b1 == n_q) ? S_DONE : S_READ;
        end
        S_DONE: begin
          if (!out_valid_q) begin
            out_val_q   <= acc_q;
            out_sat_q   <= sat_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign mul_req_o                = mreq_q;
  assign out_o.valid              = out_valid_q;
  assign out_o.interpolated_value = out_val_q;
  assign out_o.saturated          = out_sat_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> idx_q < n_q)
    else $error("table read past the centre count");

  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NORM |-> nrm_q != '0)
    else $error("leading-one search on zero");

  a_done_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
    else $error("finished query not posted");

  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q) != S_IDLE && $past(sat_q) |-> sat_q)
    else $error("clip flag dropped within a query");

endmodule

[sv/rbf_interpolant_evaluator.sv]
// Top level: RBF interpolant evaluator (thin plate, biharmonic, triharmonic kernels).
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    opcode, center_index, point_x/y/z, weight
//   out_o    out  valid/ready    interpolated_value, saturated
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i (no wait)
//
// A load is written to the centre table when the back end accepts it. A query runs the
// per-centre sequencer once for each of its n centres, using the shared multiplier; the
// work per centre depends on the kernel kind and, for thin plate, on whether the distance
// is zero and on the leading-one search.
// Reset clears control and configuration; the centre table is not cleared.
// A two-word queue lets the front keep accepting while the back end works, and a
// finished result waits in the output register while the next query is computed.
module rbf_interpolant_evaluator import rbf_pkg::*; #(
  parameter int MAX_CENTERS   = MAX_CENTERS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rbf_in_if.sink              in_i,
  rbf_out_if.source           out_o
);

  rbf_item_t    item;
  logic         item_valid, item_ready;
  rbf_mul_req_t mul_req;
  rbf_mul_rsp_t mul_rsp;

  rbf_front #(.MAX_CENTERS(MAX_CENTERS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  rbf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  rbf_back #(.MAX_CENTERS(MAX_CENTERS), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .mul_req_o    (mul_req),
    .mul_rsp_i    (mul_rsp),
    .out_o        (out_o)
  );

endmodule
